>>> rtl/lpkd_pkg.sv
`timescale 1ns / 1ps

package lpkd_pkg;

   // default key length and per-run result cap
   localparam int KEY_BYTES_DEF    = 32;
   localparam int MAX_OUT          = 32;
   // seed queue between front and back, power of two
   localparam int SEED_QUEUE_DEPTH = 2;

   // request and result payloads
   typedef struct packed {
      logic [7:0] password_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] key_byte;
      logic       last_key;
   } rsp_type;

   // finished seed handed from front to back
   typedef struct packed {
      logic        valid;
      logic [31:0] seed;
   } seed_type;

   // result of eight lfsr ticks
   typedef struct packed {
      logic [31:0] lfsr;
      logic [7:0]  bits;
   } lfsr8_type;

   // aes forward s-box
   localparam logic [7:0] SBOX [256] = '{
      8'h63, 8'h7C, 8'h77, 8'h7B, 8'hF2, 8'h6B, 8'h6F, 8'hC5,
      8'h30, 8'h01, 8'h67, 8'h2B, 8'hFE, 8'hD7, 8'hAB, 8'h76,
      8'hCA, 8'h82, 8'hC9, 8'h7D, 8'hFA, 8'h59, 8'h47, 8'hF0,
      8'hAD, 8'hD4, 8'hA2, 8'hAF, 8'h9C, 8'hA4, 8'h72, 8'hC0,
      8'hB7, 8'hFD, 8'h93, 8'h26, 8'h36, 8'h3F, 8'hF7, 8'hCC,
      8'h34, 8'hA5, 8'hE5, 8'hF1, 8'h71, 8'hD8, 8'h31, 8'h15,
      8'h04, 8'hC7, 8'h23, 8'hC3, 8'h18, 8'h96, 8'h05, 8'h9A,
      8'h07, 8'h12, 8'h80, 8'hE2, 8'hEB, 8'h27, 8'hB2, 8'h75,
      8'h09, 8'h83, 8'h2C, 8'h1A, 8'h1B, 8'h6E, 8'h5A, 8'hA0,
      8'h52, 8'h3B, 8'hD6, 8'hB3, 8'h29, 8'hE3, 8'h2F, 8'h84,
      8'h53, 8'hD1, 8'h00, 8'hED, 8'h20, 8'hFC, 8'hB1, 8'h5B,
      8'h6A, 8'hCB, 8'hBE, 8'h39, 8'h4A, 8'h4C, 8'h58, 8'hCF,
      8'hD0, 8'hEF, 8'hAA, 8'hFB, 8'h43, 8'h4D, 8'h33, 8'h85,
      8'h45, 8'hF9, 8'h02, 8'h7F, 8'h50, 8'h3C, 8'h9F, 8'hA8,
      8'h51, 8'hA3, 8'h40, 8'h8F, 8'h92, 8'h9D, 8'h38, 8'hF5,
      8'hBC, 8'hB6, 8'hDA, 8'h21, 8'h10, 8'hFF, 8'hF3, 8'hD2,
      8'hCD, 8'h0C, 8'h13, 8'hEC, 8'h5F, 8'h97, 8'h44, 8'h17,
      8'hC4, 8'hA7, 8'h7E, 8'h3D, 8'h64, 8'h5D, 8'h19, 8'h73,
      8'h60, 8'h81, 8'h4F, 8'hDC, 8'h22, 8'h2A, 8'h90, 8'h88,
      8'h46, 8'hEE, 8'hB8, 8'h14, 8'hDE, 8'h5E, 8'h0B, 8'hDB,
      8'hE0, 8'h32, 8'h3A, 8'h0A, 8'h49, 8'h06, 8'h24, 8'h5C,
      8'hC2, 8'hD3, 8'hAC, 8'h62, 8'h91, 8'h95, 8'hE4, 8'h79,
      8'hE7, 8'hC8, 8'h37, 8'h6D, 8'h8D, 8'hD5, 8'h4E, 8'hA9,
      8'h6C, 8'h56, 8'hF4, 8'hEA, 8'h65, 8'h7A, 8'hAE, 8'h08,
      8'hBA, 8'h78, 8'h25, 8'h2E, 8'h1C, 8'hA6, 8'hB4, 8'hC6,
      8'hE8, 8'hDD, 8'h74, 8'h1F, 8'h4B, 8'hBD, 8'h8B, 8'h8A,
      8'h70, 8'h3E, 8'hB5, 8'h66, 8'h48, 8'h03, 8'hF6, 8'h0E,
      8'h61, 8'h35, 8'h57, 8'hB9, 8'h86, 8'hC1, 8'h1D, 8'h9E,
      8'hE1, 8'hF8, 8'h98, 8'h11, 8'h69, 8'hD9, 8'h8E, 8'h94,
      8'h9B, 8'h1E, 8'h87, 8'hE9, 8'hCE, 8'h55, 8'h28, 8'hDF,
      8'h8C, 8'hA1, 8'h89, 8'h0D, 8'hBF, 8'hE6, 8'h42, 8'h68,
      8'h41, 8'h99, 8'h2D, 8'h0F, 8'hB0, 8'h54, 8'hBB, 8'h16
   };

   // eight lfsr ticks: taps 31, 6, 4, 2, 1, 0, shift right, new bit 0 out
   function automatic lfsr8_type lfsr_step8(input logic [31:0] r_in);
      lfsr8_type  res;
      logic [31:0] r;
      logic        fb;
      r        = r_in;
      res.bits = '0;
      for (int n = 0; n < 8; n++) begin
         fb       = r[31] ^ r[6] ^ r[4] ^ r[2] ^ r[1] ^ r[0];
         r        = {fb, r[31:1]};
         res.bits = {res.bits[6:0], r[0]};
      end
      res.lfsr = r;
      return res;
   endfunction

endpackage

>>> rtl/lpkd_front.sv
`timescale 1ns / 1ps

module lpkd_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  lpkd_pkg::req_type req_payload,
   input  logic              queue_full,
   output lpkd_pkg::seed_type seed_push
);
   import lpkd_pkg::*;

   logic [31:0] seed_ff;
   logic [31:0] seed_in;
   logic [31:0] fold;
   logic        accept;

   // stall while the seed queue has no room
   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   // seed * 33 plus the sign-extended byte
   assign fold = (seed_ff << 5) + seed_ff
               + {{24{req_payload.password_byte[7]}}, req_payload.password_byte};

   // hand the finished seed over, a zero seed becomes one
   always_comb begin
      seed_push.valid = accept && req_payload.last_byte;
      seed_push.seed  = (fold == 32'd0) ? 32'd1 : fold;
   end

   // accumulator restarts after the last byte
   always_comb begin
      seed_in = seed_ff;
      if (accept) begin
         seed_in = req_payload.last_byte ? 32'd0 : fold;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= '0;
      end else begin
         seed_ff <= seed_in;
      end
   end

endmodule

>>> rtl/lpkd_queue.sv
`timescale 1ns / 1ps

module lpkd_queue (
   input  logic               clock,
   input  logic               reset,
   input  lpkd_pkg::seed_type seed_push,
   input  logic               seed_pop,
   output lpkd_pkg::seed_type seed_head,
   output logic               queue_full
);
   import lpkd_pkg::*;

   localparam int PTR_W = (SEED_QUEUE_DEPTH > 1) ? $clog2(SEED_QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(SEED_QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(SEED_QUEUE_DEPTH);

   logic [31:0]      entry_ff [SEED_QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign queue_full     = (count_ff == DEPTH_CNT);
   assign seed_head.valid = (count_ff != '0);
   assign seed_head.seed  = entry_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (seed_push.valid) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (seed_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (seed_push.valid && !seed_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!seed_push.valid && seed_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // seed storage
   always_ff @(posedge clock) begin
      if (seed_push.valid) begin
         entry_ff[wr_ptr_ff] <= seed_push.seed;
      end
   end

   a_no_push_when_full : assert property (@(posedge clock) disable iff (reset)
      seed_push.valid |-> (count_ff != DEPTH_CNT))
      else $error("seed pushed into a full queue");

   a_no_pop_when_empty : assert property (@(posedge clock) disable iff (reset)
      seed_pop |-> (count_ff != '0))
      else $error("seed popped from an empty queue");

endmodule

>>> rtl/lpkd_back.sv
`timescale 1ns / 1ps

module lpkd_back #(
   parameter int KEY_BYTES = lpkd_pkg::KEY_BYTES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  lpkd_pkg::seed_type seed_head,
   output logic               seed_pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output lpkd_pkg::rsp_type  rsp_payload
);
   import lpkd_pkg::*;

   localparam int TOTAL  = (KEY_BYTES < MAX_OUT) ? KEY_BYTES : MAX_OUT;
   localparam int NWORDS = (TOTAL + 3) / 4;
   localparam int KCNT_W = $clog2(TOTAL + 1);
   localparam int WCNT_W = $clog2(NWORDS + 1);
   localparam logic [KCNT_W-1:0] LAST_IDX   = KCNT_W'(TOTAL - 1);
   localparam logic [KCNT_W-1:0] TOTAL_CNT  = KCNT_W'(TOTAL);
   localparam logic [WCNT_W-1:0] WORDS_INIT = WCNT_W'(NWORDS);

   logic              run_ff, run_in;
   logic [31:0]       lfsr_ff, lfsr_in;
   logic [31:0]       gen_word_ff, gen_word_in;
   logic [1:0]        gen_cnt_ff, gen_cnt_in;
   logic              gen_full_ff, gen_full_in;
   logic [WCNT_W-1:0] gen_left_ff, gen_left_in;
   logic [31:0]       emit_word_ff, emit_word_in;
   logic              emit_valid_ff, emit_valid_in;
   logic [1:0]        emit_idx_ff, emit_idx_in;
   logic [KCNT_W-1:0] key_cnt_ff, key_cnt_in;
   logic [7:0]        prev_key_ff, prev_key_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic      start;
   logic      out_free;
   logic      emit_fire;
   logic      emit_last;
   logic      word_done;
   logic      transfer;
   logic      gen_go;
   lfsr8_type step;
   logic [7:0] raw_byte;
   logic [7:0] key;

   // handshake decisions
   assign start     = !run_ff && seed_head.valid;
   assign seed_pop  = start;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign emit_fire = emit_valid_ff && out_free;
   assign emit_last = emit_fire && (key_cnt_ff == LAST_IDX);
   assign word_done = emit_fire && (emit_idx_ff == 2'd3);
   assign transfer  = run_ff && gen_full_ff && (!emit_valid_ff || word_done);
   assign gen_go    = run_ff && (gen_left_ff != '0) && (!gen_full_ff || transfer);

   // generator advances eight ticks, emitter picks bytes low first
   assign step     = lfsr_step8(lfsr_ff);
   assign raw_byte = emit_word_ff[{emit_idx_ff, 3'b000} +: 8];
   assign key      = SBOX[raw_byte] ^ prev_key_ff;

   // run control, word generator and byte emitter
   always_comb begin
      run_in        = run_ff;
      lfsr_in       = lfsr_ff;
      gen_word_in   = gen_word_ff;
      gen_cnt_in    = gen_cnt_ff;
      gen_full_in   = gen_full_ff;
      gen_left_in   = gen_left_ff;
      emit_word_in  = emit_word_ff;
      emit_valid_in = emit_valid_ff;
      emit_idx_in   = emit_idx_ff;
      key_cnt_in    = key_cnt_ff;
      prev_key_in   = prev_key_ff;
      if (start) begin
         run_in        = 1'b1;
         lfsr_in       = seed_head.seed;
         gen_cnt_in    = '0;
         gen_full_in   = 1'b0;
         gen_left_in   = WORDS_INIT;
         emit_valid_in = 1'b0;
         emit_idx_in   = '0;
         key_cnt_in    = '0;
         prev_key_in   = '0;
      end else begin
         if (emit_fire) begin
            prev_key_in = key;
            key_cnt_in  = key_cnt_ff + 1'b1;
            emit_idx_in = emit_idx_ff + 2'd1;
         end
         if (word_done) begin
            emit_valid_in = 1'b0;
         end
         if (transfer) begin
            emit_word_in  = gen_word_ff;
            emit_valid_in = 1'b1;
            emit_idx_in   = '0;
            gen_full_in   = 1'b0;
         end
         if (gen_go) begin
            lfsr_in     = step.lfsr;
            gen_word_in = {gen_word_ff[23:0], step.bits};
            gen_cnt_in  = gen_cnt_ff + 2'd1;
            if (gen_cnt_ff == 2'd3) begin
               gen_full_in = 1'b1;
               gen_left_in = gen_left_ff - 1'b1;
            end
         end
         if (emit_last) begin
            run_in        = 1'b0;
            emit_valid_in = 1'b0;
         end
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_free) begin
         rsp_valid_in = emit_fire;
      end
      if (emit_fire) begin
         rsp_data_in.key_byte = key;
         rsp_data_in.last_key = (key_cnt_ff == LAST_IDX);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff        <= 1'b0;
         gen_cnt_ff    <= '0;
         gen_full_ff   <= 1'b0;
         gen_left_ff   <= '0;
         emit_valid_ff <= 1'b0;
         emit_idx_ff   <= '0;
         key_cnt_ff    <= '0;
         prev_key_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
         lfsr_ff       <= 32'd1;
      end else begin
         run_ff        <= run_in;
         gen_cnt_ff    <= gen_cnt_in;
         gen_full_ff   <= gen_full_in;
         gen_left_ff   <= gen_left_in;
         emit_valid_ff <= emit_valid_in;
         emit_idx_ff   <= emit_idx_in;
         key_cnt_ff    <= key_cnt_in;
         prev_key_ff   <= prev_key_in;
         rsp_valid_ff  <= rsp_valid_in;
         lfsr_ff       <= lfsr_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      gen_word_ff  <= gen_word_in;
      emit_word_ff <= emit_word_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   a_last_ends_run : assert property (@(posedge clock) disable iff (reset)
      emit_last |=> !run_ff)
      else $error("run still active after its final key byte");

   a_count_in_range : assert property (@(posedge clock) disable iff (reset)
      run_ff |-> (key_cnt_ff < TOTAL_CNT))
      else $error("key byte count ran past the key length");

   a_emit_inside_run : assert property (@(posedge clock) disable iff (reset)
      (emit_valid_ff || gen_full_ff) |-> run_ff)
      else $error("word buffered outside a run");

endmodule

>>> rtl/lfsr_password_key_derivation_core.sv
`timescale 1ns / 1ps

// Password key derivation core.
// Requests carry one password byte each on req_payload; last_byte marks the
// final character. Each byte is folded into a 32-bit seed (seed * 33 plus the
// byte as a signed char), one request per cycle while the seed queue has
// room. On the last byte the seed (one if it is zero) loads an LFSR, and
// min(KEY_BYTES, 32) key bytes follow on the rsp channel, last_key set on
// the final one. Throughput: one password byte per cycle while the queue
// has room; one key byte per cycle during a burst while rsp_stall is low,
// as the 8-tick LFSR stage builds the next word while one is emitted.
// A seed passes the seed queue, word generator, byte emitter and output
// register to rsp_valid; a new run starts only once the last has ended.
// A two-entry seed queue lets the next password be folded while a burst is
// still going; req_stall rises only when that queue is full.
// When the receiver holds rsp_stall the result stays in the output register
// and the burst pauses; nothing is dropped.
// Reset (synchronous, active high) clears the seed, the queue and any burst.

module lfsr_password_key_derivation_core #(
   parameter int KEY_BYTES = lpkd_pkg::KEY_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  lpkd_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output lpkd_pkg::rsp_type rsp_payload
);
   import lpkd_pkg::*;

   seed_type seed_push;
   seed_type seed_head;
   logic     queue_full;
   logic     seed_pop;

   // request side: seed fold
   lpkd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .queue_full  (queue_full),
      .seed_push   (seed_push)
   );

   // finished seeds waiting for the back end
   lpkd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .seed_push  (seed_push),
      .seed_pop   (seed_pop),
      .seed_head  (seed_head),
      .queue_full (queue_full)
   );

   // key generation and result channel
   lpkd_back #(
      .KEY_BYTES (KEY_BYTES)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .seed_head   (seed_head),
      .seed_pop    (seed_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps

// predicts the key bytes of each password and checks them in order
class key_scoreboard;
   int                unsigned key_len;
   logic [31:0]       seed_acc;
   logic [31:0]       lfsr_state;
   logic [31:0]       rand_word;
   logic [7:0]        prev_key;
   lpkd_pkg::rsp_type expected_keys [$];
   int                unsigned key_index;
   int                unsigned errors;

   function new(int unsigned len);
      key_len    = len;
      seed_acc   = '0;
      lfsr_state = 32'h0000_0001;
      rand_word  = '0;
      prev_key   = '0;
      key_index  = 0;
      errors     = 0;
   endfunction

   // one lfsr tick, returns the new bit 0
   function logic lfsr_tick();
      logic fb;
      fb = lfsr_state[31] ^ lfsr_state[6] ^ lfsr_state[4] ^ lfsr_state[2] ^
           lfsr_state[1] ^ lfsr_state[0];
      lfsr_state = {fb, lfsr_state[31:1]};
      return lfsr_state[0];
   endfunction

   // fold an accepted password byte; the last one yields a whole key
   function void note_password_byte(lpkd_pkg::req_type req);
      lpkd_pkg::rsp_type key;
      logic [7:0]        raw;
      seed_acc = seed_acc * 32'd33 + {{24{req.password_byte[7]}}, req.password_byte};
      if (!req.last_byte) return;
      // a zero seed would lock the lfsr, so it loads one instead
      lfsr_state = (seed_acc == 32'd0) ? 32'h0000_0001 : seed_acc;
      seed_acc   = '0;
      prev_key   = '0;
      for (int unsigned i = 0; i < key_len; i++) begin
         if (i % 4 == 0) begin
            rand_word = '0;
            for (int n = 0; n < 32; n++) rand_word = {rand_word[30:0], lfsr_tick()};
         end
         raw          = rand_word[8 * (i % 4) +: 8];
         key.key_byte = lpkd_pkg::SBOX[raw] ^ prev_key;
         key.last_key = (i == key_len - 1);
         prev_key     = key.key_byte;
         expected_keys.push_back(key);
      end
   endfunction

   task report_mismatch(string msg);
      $display("mismatch: %s", msg);
      errors++;
   endtask

   // compare one accepted key byte against the oldest prediction
   task check_key_byte(lpkd_pkg::rsp_type got);
      lpkd_pkg::rsp_type want;
      if (expected_keys.size() == 0) begin
         report_mismatch($sformatf("unexpected key byte %02h last %0b",
                                   got.key_byte, got.last_key));
         return;
      end
      want = expected_keys.pop_front();
      if (got.key_byte !== want.key_byte)
         report_mismatch($sformatf("key byte %0d: got %02h want %02h",
                                   key_index, got.key_byte, want.key_byte));
      if (got.last_key !== want.last_key)
         report_mismatch($sformatf("key byte %0d: last_key got %0b want %0b",
                                   key_index, got.last_key, want.last_key));
      key_index++;
   endtask
endclass

module tb_top;
   import lpkd_pkg::*;

   localparam int          KEY_LEN     = KEY_BYTES_DEF;
   localparam int unsigned RUN_LEN     = (KEY_LEN < MAX_OUT) ? KEY_LEN : MAX_OUT;
   localparam int unsigned RANDOM_REQS = 310;
   localparam int unsigned CYCLE_LIMIT = 400000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_payload;

   // no idling on either side while set
   bit          calm;
   int unsigned cycle_count;
   key_scoreboard sb;

   lfsr_password_key_derivation_core #(
      .KEY_BYTES(KEY_LEN)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run time guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // receiver back pressure
   always @(negedge clock) begin
      rsp_stall <= !calm && ($urandom_range(99) < 17);
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_key_byte(rsp_payload);
   end

   // drive one request, with random idle cycles ahead of it
   task automatic send_request(input req_type req);
      bit taken;
      @(negedge clock);
      while (!calm && ($urandom_range(99) < 17)) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= req;
      taken = 1'b0;
      while (!taken) begin
         @(posedge clock);
         if (!req_stall) taken = 1'b1;
      end
      sb.note_password_byte(req);
   endtask

   // mostly random bytes, with extra weight on the sign and range edges
   function automatic logic [7:0] pick_byte();
      logic [7:0] edges [4] = '{8'h00, 8'h7F, 8'h80, 8'hFF};
      if ($urandom_range(3) == 0) return edges[$urandom_range(3)];
      return 8'($urandom);
   endfunction

   initial begin
      req_type     directed [$];
      req_type     req;
      int unsigned sent;
      int unsigned len;
      sb          = new(RUN_LEN);
      calm        = 1'b0;
      cycle_count = 0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      rsp_stall   = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // single zero byte: seed stays zero and the lfsr loads one
      directed.push_back('{8'h00, 1'b1});
      // 1 * 33 - 33 folds back to a zero seed
      directed.push_back('{8'h01, 1'b0});
      directed.push_back('{8'hDF, 1'b1});
      // sign edges as one-byte passwords
      directed.push_back('{8'h80, 1'b1});
      directed.push_back('{8'h7F, 1'b1});
      directed.push_back('{8'hFF, 1'b1});
      // zero bytes inside a password
      directed.push_back('{8'h00, 1'b0});
      directed.push_back('{8'h00, 1'b0});
      directed.push_back('{8'h41, 1'b1});
      // plain ascii password
      directed.push_back('{8'h73, 1'b0});
      directed.push_back('{8'h65, 1'b0});
      directed.push_back('{8'h63, 1'b0});
      directed.push_back('{8'h72, 1'b0});
      directed.push_back('{8'h65, 1'b0});
      directed.push_back('{8'h74, 1'b1});
      // negative bytes only
      directed.push_back('{8'hFF, 1'b0});
      directed.push_back('{8'h80, 1'b0});
      directed.push_back('{8'hFF, 1'b0});
      directed.push_back('{8'h80, 1'b1});
      foreach (directed[i]) send_request(directed[i]);

      // random passwords, some long enough to wrap the seed, plus loose bytes
      sent = 0;
      while (sent < RANDOM_REQS) begin
         calm = (sent >= 120 && sent < 200);
         if ($urandom_range(99) < 80) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
            for (int unsigned k = 1; k <= len; k++) begin
               req.password_byte = pick_byte();
               req.last_byte     = (k == len);
               send_request(req);
            end
            sent += len;
         end else begin
            req.password_byte = pick_byte();
            req.last_byte     = 1'($urandom_range(1));
            send_request(req);
            sent++;
         end
      end
      calm = 1'b0;
      // close any open password
      req.password_byte = pick_byte();
      req.last_byte     = 1'b1;
      send_request(req);
      @(negedge clock);
      req_valid <= 1'b0;

      // drain, then give the core time to show any stray output
      while (sb.expected_keys.size() != 0) @(posedge clock);
      repeat (RUN_LEN + 40) @(posedge clock);
      if (sb.expected_keys.size() != 0)
         sb.report_mismatch($sformatf("%0d key bytes never arrived",
                                      sb.expected_keys.size()));

      if (sb.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule
